>>> design/intel_hex_line_parser_macros.svh
// Assertion macros used by the Intel HEX line parser RTL.
`ifndef INTEL_HEX_LINE_PARSER_MACROS_SVH
`define INTEL_HEX_LINE_PARSER_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define IHEX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define IHEX_ASSERT_NEXT(label, cond, next, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (next)) \
		else $error(msg);

`endif

>>> design/ihex_pkg.sv
// Package with the types, codes and helpers of the Intel HEX line parser.
`default_nettype none

package ihex_pkg;

	// Default longest line, in kept characters, that is still decoded.
	localparam int MAX_LINE_DEF = 511;

	// Shortest well-formed record: mark, length, address, type and checksum.
	localparam int MIN_LINE = 11;

	// Result kinds.
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_LINE = 1'b1;

	// Line-end status codes, in order of precedence.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_AFTER_END = 3'd1;
	localparam logic [2:0] ST_SHORT    = 3'd2;
	localparam logic [2:0] ST_MARK     = 3'd3;
	localparam logic [2:0] ST_NONHEX   = 3'd4;
	localparam logic [2:0] ST_LENGTH   = 3'd5;
	localparam logic [2:0] ST_TYPE     = 3'd6;
	localparam logic [2:0] ST_CHECKSUM = 3'd7;

	// Record types.
	localparam logic [7:0] TYPE_DATA    = 8'h00;
	localparam logic [7:0] TYPE_EOF     = 8'h01;
	localparam logic [7:0] TYPE_EXT_LIN = 8'h04;
	localparam logic [7:0] TYPE_MAX     = 8'h05;

	// Characters with a meaning of their own.
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_STAR  = 8'h2A;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UF    = 8'h46;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LF_HEX = 8'h66;

	// Per-line flags and fields that decide the line-end status.
	typedef struct packed {
		logic       end_seen;
		logic       mark_bad;
		logic       nonhex_seen;
		logic [7:0] declared_len;
		logic [7:0] type_byte;
		logic [7:0] sum_acc;
	} line_flags_t;

	// Decodes one hex digit: bit 4 is set when the character is a hex digit.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		logic [7:0] d;
		r = 5'd0;
		d = 8'd0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			d = c - CHAR_0;
			r = {1'b1, d[3:0]};
		end else if (c >= CHAR_UA && c <= CHAR_UF) begin
			d = c - CHAR_UA + 8'd10;
			r = {1'b1, d[3:0]};
		end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
			d = c - CHAR_LA + 8'd10;
			r = {1'b1, d[3:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> design/ihex_status.sv
// Line-end status check of the Intel HEX line parser.
`default_nettype none

module ihex_status
	import ihex_pkg::*;
#(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  wire logic [$clog2(MAX_LINE + 2) - 1:0] char_count,
	input  wire line_flags_t                       flags,
	output logic [2:0]                             status
);

	localparam int CNT_W = $clog2(MAX_LINE + 2);
	localparam int CMP_W = (CNT_W > 10) ? CNT_W : 10;

	logic             over;
	logic             too_short;
	logic [CMP_W-1:0] expected;
	logic [CMP_W-1:0] count_ext;

	// A kept-character count of 11 + 2 * length marks a complete record.
	assign over      = char_count > CNT_W'(MAX_LINE);
	assign too_short = (char_count < CNT_W'(MIN_LINE)) || (!over && !char_count[0]);
	assign expected  = CMP_W'(MIN_LINE) + CMP_W'({flags.declared_len, 1'b0});
	assign count_ext = CMP_W'(char_count);

	// Pick the first failing check in order of precedence.
	always_comb begin
		if (flags.end_seen) begin
			status = ST_AFTER_END;
		end else if (too_short) begin
			status = ST_SHORT;
		end else if (flags.mark_bad) begin
			status = ST_MARK;
		end else if (flags.nonhex_seen) begin
			status = ST_NONHEX;
		end else if (over || (expected != count_ext)) begin
			status = ST_LENGTH;
		end else if (flags.type_byte > TYPE_MAX) begin
			status = ST_TYPE;
		end else if (flags.sum_acc != 8'd0) begin
			status = ST_CHECKSUM;
		end else begin
			status = ST_OK;
		end
	end

endmodule

`default_nettype wire

>>> design/intel_hex_line_parser.sv
// Top level of the Intel HEX line parser.
`default_nettype none
`include "intel_hex_line_parser_macros.svh"

// Takes Intel HEX text one character per item and returns tentative data-byte
// items and one line-end item per newline. Each character is held in an input
// register, decoded against the line state and written to an output register,
// so a new character is taken every cycle while the output side keeps up; a
// character's item is offered at the output from that output register. The only
// limit on rate is the single output register: when its item is not taken, the
// input register fills and the input stalls.
// Data bytes are sent before their line is checked, so an error status at the
// line end voids them, and after any error status the block swallows all input
// until reset.
module intel_hex_line_parser
	import ihex_pkg::*;
#(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  ch,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic [31:0]      byte_address,
	output logic [7:0]       data_value,
	output logic [2:0]       status,
	output logic [7:0]       rec_type,
	output logic [7:0]       rec_len
);

	localparam int CNT_W = $clog2(MAX_LINE + 2);
	localparam int IDX_W = (CNT_W > 8) ? CNT_W : 8;

	// Input register.
	logic       valid_s1;
	logic [7:0] ch_s1;

	// Line state.
	logic [CNT_W-1:0] char_count_q, char_count_n;
	logic             raw_first_q, raw_first_n;
	logic             comment_q, comment_n;
	logic             mark_bad_q, mark_bad_n;
	logic             nonhex_q, nonhex_n;
	logic [3:0]       high_nib_q, high_nib_n;
	logic [CNT_W-1:0] byte_idx_q, byte_idx_n;
	logic [7:0]       len_q, len_n;
	logic [15:0]      offset_q, offset_n;
	logic [7:0]       type_q, type_n;
	logic [7:0]       sum_q, sum_n;
	logic [15:0]      first_two_q, first_two_n;
	logic [15:0]      upper_q, upper_n;
	logic             end_seen_q, end_seen_n;
	logic             halted_q, halted_n;

	// Output register.
	logic        out_valid_q;
	logic        kind_q;
	logic [31:0] addr_q;
	logic [7:0]  data_q;
	logic [2:0]  status_q;
	logic [7:0]  rec_type_q;
	logic [7:0]  rec_len_q;

	// Per-character decode.
	logic             advance;
	logic             res_load;
	logic             res_kind;
	logic [31:0]      res_addr;
	logic [7:0]       res_data;
	logic [2:0]       res_status;
	logic [7:0]       res_type;
	logic [7:0]       res_len;
	logic [4:0]       hex;
	logic [7:0]       byte_val;
	logic [CNT_W-1:0] data_idx;
	logic [IDX_W-1:0] data_idx_ext;
	logic             is_comment;
	logic [2:0]       line_st;
	line_flags_t      flags;
	logic             data_load;

	// The character moves on when the output register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign hex          = hex_decode(ch_s1);
	assign byte_val     = {high_nib_q, hex[3:0]};
	assign data_idx     = byte_idx_q - CNT_W'(4);
	assign data_idx_ext = IDX_W'(data_idx);
	assign is_comment   = comment_q || (raw_first_q && ch_s1 == CHAR_STAR);
	assign data_load    = advance && res_load && (res_kind == KIND_DATA);

	assign flags = '{
		end_seen:     end_seen_q,
		mark_bad:     mark_bad_q,
		nonhex_seen:  nonhex_q,
		declared_len: len_q,
		type_byte:    type_q,
		sum_acc:      sum_q
	};

	ihex_status #(
		.MAX_LINE(MAX_LINE)
	) u_status (
		.char_count(char_count_q),
		.flags     (flags),
		.status    (line_st)
	);

	// Next line state and result for the character in the input register.
	always_comb begin
		char_count_n = char_count_q;
		raw_first_n  = raw_first_q;
		comment_n    = comment_q;
		mark_bad_n   = mark_bad_q;
		nonhex_n     = nonhex_q;
		high_nib_n   = high_nib_q;
		byte_idx_n   = byte_idx_q;
		len_n        = len_q;
		offset_n     = offset_q;
		type_n       = type_q;
		sum_n        = sum_q;
		first_two_n  = first_two_q;
		upper_n      = upper_q;
		end_seen_n   = end_seen_q;
		halted_n     = halted_q;
		res_load     = 1'b0;
		res_kind     = KIND_DATA;
		res_addr     = 32'd0;
		res_data     = 8'd0;
		res_status   = ST_OK;
		res_type     = 8'd0;
		res_len      = 8'd0;
		if (halted_q) begin
			res_load = 1'b0;
		end else if (ch_s1 == CHAR_LF) begin
			res_load = 1'b1;
			res_kind = KIND_LINE;
			if (!comment_q && char_count_q != '0) begin
				res_status = line_st;
				res_type   = type_q;
				res_len    = len_q;
				if (line_st != ST_OK) begin
					halted_n = 1'b1;
				end else if (type_q == TYPE_EXT_LIN) begin
					upper_n = first_two_q;
				end else if (type_q == TYPE_EOF) begin
					end_seen_n = 1'b1;
				end
			end
			char_count_n = '0;
			raw_first_n  = 1'b1;
			comment_n    = 1'b0;
			mark_bad_n   = 1'b0;
			nonhex_n     = 1'b0;
			high_nib_n   = 4'd0;
			byte_idx_n   = '0;
			len_n        = 8'd0;
			offset_n     = 16'd0;
			type_n       = 8'd0;
			sum_n        = 8'd0;
			first_two_n  = 16'd0;
		end else begin
			raw_first_n = 1'b0;
			if (is_comment) begin
				comment_n = 1'b1;
			end else if (ch_s1 == CHAR_SPACE || ch_s1 == CHAR_TAB || ch_s1 == CHAR_CR) begin
				comment_n = comment_q;
			end else if (char_count_q <= CNT_W'(MAX_LINE)) begin
				char_count_n = char_count_q + CNT_W'(1);
				if (char_count_q == '0) begin
					mark_bad_n = (ch_s1 != CHAR_COLON);
				end else if (!hex[4]) begin
					nonhex_n = 1'b1;
				end else if (char_count_q[0]) begin
					high_nib_n = hex[3:0];
				end else begin
					// A complete byte: header fields first, then data.
					byte_idx_n = byte_idx_q + CNT_W'(1);
					sum_n      = sum_q + byte_val;
					if (byte_idx_q == CNT_W'(0)) begin
						len_n = byte_val;
					end else if (byte_idx_q == CNT_W'(1)) begin
						offset_n = {byte_val, offset_q[7:0]};
					end else if (byte_idx_q == CNT_W'(2)) begin
						offset_n = {offset_q[15:8], byte_val};
					end else if (byte_idx_q == CNT_W'(3)) begin
						type_n = byte_val;
					end else if (data_idx_ext < IDX_W'(len_q)) begin
						if (data_idx == CNT_W'(0)) begin
							first_two_n = {byte_val, first_two_q[7:0]};
						end
						if (data_idx == CNT_W'(1)) begin
							first_two_n = {first_two_q[15:8], byte_val};
						end
						if (type_q == TYPE_DATA && !mark_bad_q && !nonhex_q && !end_seen_q) begin
							res_load = 1'b1;
							res_kind = KIND_DATA;
							res_addr = {upper_q, offset_q} + 32'(data_idx);
							res_data = byte_val;
						end
					end
				end
			end
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1 <= ch;
		end
	end

	// Line state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
			raw_first_q  <= 1'b1;
			comment_q    <= 1'b0;
			mark_bad_q   <= 1'b0;
			nonhex_q     <= 1'b0;
			high_nib_q   <= 4'd0;
			byte_idx_q   <= '0;
			len_q        <= 8'd0;
			offset_q     <= 16'd0;
			type_q       <= 8'd0;
			sum_q        <= 8'd0;
			first_two_q  <= 16'd0;
			upper_q      <= 16'd0;
			end_seen_q   <= 1'b0;
			halted_q     <= 1'b0;
		end else if (advance) begin
			char_count_q <= char_count_n;
			raw_first_q  <= raw_first_n;
			comment_q    <= comment_n;
			mark_bad_q   <= mark_bad_n;
			nonhex_q     <= nonhex_n;
			high_nib_q   <= high_nib_n;
			byte_idx_q   <= byte_idx_n;
			len_q        <= len_n;
			offset_q     <= offset_n;
			type_q       <= type_n;
			sum_q        <= sum_n;
			first_two_q  <= first_two_n;
			upper_q      <= upper_n;
			end_seen_q   <= end_seen_n;
			halted_q     <= halted_n;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_load;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance && res_load) begin
			kind_q     <= res_kind;
			addr_q     <= res_addr;
			data_q     <= res_data;
			status_q   <= res_status;
			rec_type_q <= res_type;
			rec_len_q  <= res_len;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign byte_address = addr_q;
	assign data_value   = data_q;
	assign status       = status_q;
	assign rec_type     = rec_type_q;
	assign rec_len      = rec_len_q;

	// A halted parser produces no further items and never leaves that state.
	`IHEX_ASSERT(a_halt_silent, !(halted_q && advance && res_load), "item produced while halted")
	`IHEX_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q, "halted state was left without reset")
	// No data byte may follow the end record or come from a comment line.
	`IHEX_ASSERT(a_no_data_after_end, !(data_load && (end_seen_q || comment_q)), "stray data byte")
	// The kept-character count saturates one past the decode limit.
	`IHEX_ASSERT(a_count_bound, char_count_q <= CNT_W'(MAX_LINE + 1), "character count past limit")

endmodule

`default_nettype wire
